// ===== rtl/dhcpv6_relay_reply_option_parser_macros.svh =====
// Assertion macros for the relay-reply option parser.
// Each expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef DHCPV6_RELAY_REPLY_OPTION_PARSER_MACROS_SVH
`define DHCPV6_RELAY_REPLY_OPTION_PARSER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define DRP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define DRP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define DRP_ASSERT(lbl, prop, msg)
`define DRP_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/dhcp_rrp_pkg.sv =====
package dhcp_rrp_pkg;

	localparam int RELAY_HEADER_BYTES = 34;
	localparam int IANA_SKIP = 14;
	localparam int ADDR_BYTES = 16;
	localparam int TXID_BYTES = 3;
	localparam logic [3:0] ALL_FOUND = 4'hf;

	localparam logic [7:0] MSG_RELAY_REPLY = 8'd13;
	localparam logic [7:0] MSG_ADVERTISE = 8'd2;
	localparam logic [7:0] MSG_REPLY = 8'd7;

	localparam logic [15:0] OPT_PAD = 16'd0;
	localparam logic [15:0] OPT_CLIENTID = 16'd1;
	localparam logic [15:0] OPT_SERVERID = 16'd2;
	localparam logic [15:0] OPT_IA_NA = 16'd3;
	localparam logic [15:0] OPT_IAADDR = 16'd5;
	localparam logic [15:0] OPT_RELAY_MSG = 16'd9;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	typedef enum logic [3:0] {
		PH_TYPE = 4'd0,
		PH_HDR = 4'd1,
		PH_CODE_HI = 4'd2,
		PH_CODE_LO = 4'd3,
		PH_LEN_HI = 4'd4,
		PH_LEN_LO = 4'd5,
		PH_VALUE = 4'd6,
		PH_INNER = 4'd7,
		PH_TXID = 4'd8,
		PH_IANA = 4'd9
	} phase_t;

	typedef enum logic [2:0] {
		KIND_TXID = 3'd0,
		KIND_CLIENT = 3'd1,
		KIND_SERVER = 3'd2,
		KIND_ADDR = 3'd3,
		KIND_STATUS = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		ST_ADVERTISE = 2'd0,
		ST_REPLY = 2'd1,
		ST_OTHER = 2'd2,
		ST_INCOMPLETE = 2'd3
	} status_t;

	typedef struct packed {
		kind_t kind;
		logic [15:0] field_index;
		logic [7:0] data_byte;
		logic [7:0] inner_msg_type;
		status_t status;
		logic [15:0] client_id_len;
		logic [15:0] server_id_len;
		logic run_last;
	} res_t;

endpackage

// ===== rtl/dhcp_rrp_parser.sv =====
module dhcp_rrp_parser import dhcp_rrp_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic fire,
	input logic [7:0] byte_s1,
	input logic eom_s1,
	output logic [1:0] push_cnt,
	output res_t res_a,
	output res_t res_b
);

	phase_t phase_q, phase_n;
	logic [15:0] count_q, count_n;
	logic [15:0] code_q, code_n;
	logic [15:0] len_q, len_n;
	logic [3:0] found_q, found_n;
	logic relay_q, relay_n;
	logic [7:0] itype_q, itype_n;
	logic [15:0] clen_q, clen_n;
	logic [15:0] slen_q, slen_n;
	logic stopped_q, stopped_n;

	always_comb begin
		logic finish;
		logic data_ok;
		res_t data_res;
		res_t stat_res;
		status_t st;
		phase_n = phase_q;
		count_n = count_q;
		code_n = code_q;
		len_n = len_q;
		found_n = found_q;
		relay_n = relay_q;
		itype_n = itype_q;
		clen_n = clen_q;
		slen_n = slen_q;
		stopped_n = stopped_q;
		finish = 1'b0;
		data_ok = 1'b0;
		data_res = '0;
		data_res.data_byte = byte_s1;
		data_res.field_index = count_q;
		data_res.kind = KIND_TXID;
		if (!stopped_q) begin
			case (phase_q)
				PH_TYPE: begin
					if (byte_s1 != MSG_RELAY_REPLY) begin
						stopped_n = 1'b1;
					end else begin
						count_n = 16'd1;
						phase_n = (16'd1 >= 16'(RELAY_HEADER_BYTES)) ? PH_CODE_HI : PH_HDR;
					end
				end
				PH_HDR: begin
					count_n = count_q + 16'd1;
					if (count_n >= 16'(RELAY_HEADER_BYTES)) phase_n = PH_CODE_HI;
				end
				PH_CODE_HI: begin
					code_n = {byte_s1, 8'd0};
					phase_n = PH_CODE_LO;
				end
				PH_CODE_LO: begin
					code_n = {code_q[15:8], byte_s1};
					if (code_n == OPT_PAD) begin
						phase_n = PH_CODE_HI;
					end else if (relay_q && code_n == OPT_IA_NA) begin
						count_n = '0;
						phase_n = PH_IANA;
					end else begin
						phase_n = PH_LEN_HI;
					end
				end
				PH_LEN_HI: begin
					len_n = {byte_s1, 8'd0};
					phase_n = PH_LEN_LO;
				end
				PH_LEN_LO: begin
					len_n = {len_q[15:8], byte_s1};
					if (code_q == OPT_RELAY_MSG && !relay_q) begin
						phase_n = PH_INNER;
					end else begin
						if (relay_q && code_q == OPT_CLIENTID) clen_n = len_n;
						if (relay_q && code_q == OPT_SERVERID) slen_n = len_n;
						count_n = '0;
						if (len_n == 16'd0) finish = 1'b1;
						else phase_n = PH_VALUE;
					end
				end
				PH_VALUE: begin
					if (relay_q) begin
						if (code_q == OPT_CLIENTID) begin
							data_ok = 1'b1;
							data_res.kind = KIND_CLIENT;
						end else if (code_q == OPT_SERVERID) begin
							data_ok = 1'b1;
							data_res.kind = KIND_SERVER;
						end else if (code_q == OPT_IAADDR && count_q < 16'(ADDR_BYTES)) begin
							data_ok = 1'b1;
							data_res.kind = KIND_ADDR;
						end
					end
					count_n = count_q + 16'd1;
					if (count_n >= len_q) finish = 1'b1;
				end
				PH_INNER: begin
					itype_n = byte_s1;
					relay_n = 1'b1;
					if (byte_s1 != MSG_ADVERTISE) begin
						stopped_n = 1'b1;
					end else begin
						count_n = '0;
						phase_n = PH_TXID;
					end
				end
				PH_TXID: begin
					data_ok = 1'b1;
					data_res.kind = KIND_TXID;
					count_n = count_q + 16'd1;
					if (count_n >= 16'(TXID_BYTES)) begin
						found_n = found_q | 4'b0001;
						phase_n = PH_CODE_HI;
					end
				end
				PH_IANA: begin
					count_n = count_q + 16'd1;
					if (count_n >= 16'(IANA_SKIP)) phase_n = PH_CODE_HI;
				end
				default: begin
					phase_n = PH_CODE_HI;
				end
			endcase
		end
		// Closing an option records which of the wanted items it completed.
		if (finish) begin
			if (relay_q) begin
				if (code_q == OPT_CLIENTID) found_n = found_n | 4'b0010;
				else if (code_q == OPT_SERVERID) found_n = found_n | 4'b0100;
				else if (code_q == OPT_IAADDR) found_n = found_n | 4'b1000;
			end
			if ((found_n & ALL_FOUND) == ALL_FOUND) stopped_n = 1'b1;
			phase_n = PH_CODE_HI;
		end
		if (stopped_n && phase_n == PH_TYPE) st = ST_OTHER;
		else if (relay_n && itype_n == MSG_REPLY) st = ST_REPLY;
		else if (relay_n && itype_n != MSG_ADVERTISE) st = ST_OTHER;
		else if ((found_n & ALL_FOUND) == ALL_FOUND) st = ST_ADVERTISE;
		else st = ST_INCOMPLETE;
		stat_res = '0;
		stat_res.kind = KIND_STATUS;
		stat_res.inner_msg_type = itype_n;
		stat_res.status = st;
		stat_res.client_id_len = clen_n;
		stat_res.server_id_len = slen_n;
		stat_res.run_last = 1'b1;
		data_res.run_last = !eom_s1;
		if (eom_s1) begin
			phase_n = PH_TYPE;
			count_n = '0;
			code_n = '0;
			len_n = '0;
			found_n = '0;
			relay_n = 1'b0;
			itype_n = '0;
			clen_n = '0;
			slen_n = '0;
			stopped_n = 1'b0;
		end
		res_a = data_ok ? data_res : stat_res;
		res_b = stat_res;
		if (!fire) push_cnt = 2'd0;
		else push_cnt = 2'(data_ok) + 2'(eom_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TYPE;
			count_q <= '0;
			code_q <= '0;
			len_q <= '0;
			found_q <= '0;
			relay_q <= 1'b0;
			itype_q <= '0;
			clen_q <= '0;
			slen_q <= '0;
			stopped_q <= 1'b0;
		end else if (fire) begin
			phase_q <= phase_n;
			count_q <= count_n;
			code_q <= code_n;
			len_q <= len_n;
			found_q <= found_n;
			relay_q <= relay_n;
			itype_q <= itype_n;
			clen_q <= clen_n;
			slen_q <= slen_n;
			stopped_q <= stopped_n;
		end
	end

endmodule

// ===== rtl/dhcp_rrp_fifo.sv =====
`include "dhcpv6_relay_reply_option_parser_macros.svh"
module dhcp_rrp_fifo import dhcp_rrp_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic [1:0] push_cnt,
	input res_t push_a,
	input res_t push_b,
	input logic stall,
	output res_t head,
	output logic head_valid,
	output logic room2
);

	res_t mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_CNT_W-1:0] count_q;
	logic pop;

	assign head_valid = (count_q != '0);
	assign head = mem_q[rd_ptr_q];
	assign pop = head_valid && !stall;
	assign room2 = (count_q <= FIFO_CNT_W'(FIFO_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0) mem_q[wr_ptr_q] <= push_a;
		if (push_cnt == 2'd2) mem_q[wr_ptr_q + FIFO_PTR_W'(1)] <= push_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(push_cnt);
			if (pop) rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
			count_q <= count_q + FIFO_CNT_W'(push_cnt) - FIFO_CNT_W'(pop);
		end
	end

	`DRP_ASSERT(a_count_bound, count_q <= FIFO_CNT_W'(FIFO_DEPTH), "result queue count out of range")
	`DRP_ASSERT(a_no_overflow, (4'(count_q) + 4'(push_cnt)) <= (4'(FIFO_DEPTH) + 4'(pop)), "result queue overflow")
	`DRP_ASSERT_NEXT(a_count_track, 1'b1, count_q == FIFO_CNT_W'($past(count_q) + FIFO_CNT_W'($past(push_cnt)) - FIFO_CNT_W'($past(pop))), "result queue count mismatch")

endmodule

// ===== rtl/dhcpv6_relay_reply_option_parser.sv =====
// DHCPv6 relay-reply option parser. Message bytes enter on the input channel one per request,
// in wire order, with end_of_message high on the final byte. The first byte must be
// relay-reply; the relay header is skipped, the options are walked, and the inner message of
// the first relay-message option is parsed for its type, transaction id, client and server
// DUIDs and the IAADDR address inside IA_NA. Each captured byte leaves as one output request
// tagged by kind and field_index, and the final byte of a message adds a status request with
// the inner type, the verdict and the two DUID lengths; run_last marks the last request caused
// by an input byte. A byte is taken every cycle unless the input is stalled: the single option
// state machine closes its loop between the input register and the result queue. An input byte
// yields at most two requests and the output channel moves one per cycle when not stalled. Only
// a final byte yields two, and the header bytes of the next message yield none, so while the
// output side keeps up the queue never holds more than two and the input is never stalled. The
// input is stalled only after the output side has stalled long enough to leave the four-entry
// result queue without room for two more.
`include "dhcpv6_relay_reply_option_parser_macros.svh"
module dhcpv6_relay_reply_option_parser import dhcp_rrp_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [7:0] in_byte,
	input logic end_of_message,
	output logic out_valid,
	input logic out_stall,
	output logic [2:0] kind,
	output logic [15:0] field_index,
	output logic [7:0] data_byte,
	output logic [7:0] inner_msg_type,
	output logic [1:0] status,
	output logic [15:0] client_id_len,
	output logic [15:0] server_id_len,
	output logic run_last
);

	// The input register holds one byte until the result queue can take whatever it causes.
	logic valid_s1;
	logic [7:0] byte_s1;
	logic eom_s1;
	logic fire;
	logic room2;
	logic in_accept;
	logic [1:0] push_cnt;
	res_t res_a;
	res_t res_b;
	res_t head;

	assign fire = valid_s1 && room2;
	assign in_stall = valid_s1 && !room2;
	assign in_accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			byte_s1 <= in_byte;
			eom_s1 <= end_of_message;
		end
	end

	// Option walk: updates the parse state and forms up to two results per byte.
	dhcp_rrp_parser u_parser (
		.clk(clk),
		.arst_n(arst_n),
		.fire(fire),
		.byte_s1(byte_s1),
		.eom_s1(eom_s1),
		.push_cnt(push_cnt),
		.res_a(res_a),
		.res_b(res_b)
	);

	// The result queue parts the output handshake from the parse loop.
	dhcp_rrp_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push_cnt(push_cnt),
		.push_a(res_a),
		.push_b(res_b),
		.stall(out_stall),
		.head(head),
		.head_valid(out_valid),
		.room2(room2)
	);

	assign kind = head.kind;
	assign field_index = head.field_index;
	assign data_byte = head.data_byte;
	assign inner_msg_type = head.inner_msg_type;
	assign status = head.status;
	assign client_id_len = head.client_id_len;
	assign server_id_len = head.server_id_len;
	assign run_last = head.run_last;

	// A processed final byte always leaves a status request waiting on the output.
	`DRP_ASSERT_NEXT(a_eom_gives_result, fire && eom_s1, out_valid, "final byte produced no result")

endmodule

// ===== dv/tb_dhcpv6_relay_reply_option_parser.sv =====
`timescale 1ns / 100ps

// Testbench for the DHCPv6 relay-reply option parser.
//
// Whole relay-reply messages are built byte by byte and fed to the block as input requests.
// Most are well formed with random content. Others are truncated, carry a reply or some other
// inner type, start with the wrong message type, or are plain noise. A scoreboard class keeps
// its own copy of the parse state. For every accepted byte it works out which output requests
// that byte must cause, and it checks each output request against the oldest one still owed.
module tb_dhcpv6_relay_reply_option_parser import dhcp_rrp_pkg::*;;

	localparam int BYTE_TARGET = 1550;
	localparam int SCENARIO_COUNT = 7;

	typedef enum int {
		SC_ADVERTISE = 0,
		SC_SECOND_RELAY = 1,
		SC_TRUNCATED = 2,
		SC_REPLY = 3,
		SC_OTHER_TYPE = 4,
		SC_WRONG_TYPE = 5,
		SC_NOISE = 6
	} scenario_t;

	// The scoreboard tracks the parse of the current message and holds the output requests
	// that the accepted bytes have caused but that have not yet left the block.
	class option_parse_scoreboard;
		phase_t phase;
		logic [15:0] count;
		logic [15:0] code;
		logic [15:0] length;
		logic [3:0] found;
		logic relay_seen;
		logic [7:0] inner;
		logic [15:0] client_len;
		logic [15:0] server_len;
		logic halted;

		res_t expected_records[$];
		int bytes_taken;
		int records_checked;
		int mismatches;
		int messages_closed;
		int verdicts[4];

		function new();
			restart();
		endfunction

		function void restart();
			phase = PH_TYPE;
			count = '0;
			code = '0;
			length = '0;
			found = '0;
			relay_seen = 1'b0;
			inner = '0;
			client_len = '0;
			server_len = '0;
			halted = 1'b0;
		endfunction

		function void push_data(kind_t k, logic [15:0] idx, logic [7:0] d);
			res_t r;
			r = '0;
			r.kind = k;
			r.field_index = idx;
			r.data_byte = d;
			expected_records.push_back(r);
		endfunction

		// A found bit is only set when its option closes, after the last value byte if there is one.
		function void close_option();
			if (relay_seen) begin
				if (code == OPT_CLIENTID) found[1] = 1'b1;
				else if (code == OPT_SERVERID) found[2] = 1'b1;
				else if (code == OPT_IAADDR) found[3] = 1'b1;
			end
			if (found == ALL_FOUND) halted = 1'b1;
			phase = PH_CODE_HI;
		endfunction

		function string describe(res_t r);
			return $sformatf(
				"kind=%0d idx=%0d data=%02h itype=%02h status=%0d clen=%0d slen=%0d last=%0b",
				r.kind, r.field_index, r.data_byte, r.inner_msg_type, r.status,
				r.client_id_len, r.server_id_len, r.run_last);
		endfunction

		task report(string what);
			mismatches++;
			if (mismatches <= 40) $display("MISMATCH: %s", what);
		endtask

		task parse_byte(logic [7:0] b, logic eom);
			int start_len;
			logic [15:0] pos;
			status_t verdict;
			res_t r;
			start_len = expected_records.size();
			bytes_taken++;
			if (!halted) begin
				case (phase)
				PH_TYPE: begin
					if (b != MSG_RELAY_REPLY) begin
						halted = 1'b1;
					end else begin
						count = 16'd1;
						phase = (count >= RELAY_HEADER_BYTES) ? PH_CODE_HI : PH_HDR;
					end
				end
				PH_HDR: begin
					count = count + 16'd1;
					if (count >= RELAY_HEADER_BYTES) phase = PH_CODE_HI;
				end
				PH_CODE_HI: begin
					code = {b, 8'h00};
					phase = PH_CODE_LO;
				end
				PH_CODE_LO: begin
					code = {code[15:8], b};
					if (code == OPT_PAD) begin
						phase = PH_CODE_HI;
					end else if (relay_seen && code == OPT_IA_NA) begin
						count = '0;
						phase = PH_IANA;
					end else begin
						phase = PH_LEN_HI;
					end
				end
				PH_LEN_HI: begin
					length = {b, 8'h00};
					phase = PH_LEN_LO;
				end
				PH_LEN_LO: begin
					length = {length[15:8], b};
					if (code == OPT_RELAY_MSG && !relay_seen) begin
						phase = PH_INNER;
					end else begin
						if (relay_seen) begin
							if (code == OPT_CLIENTID) client_len = length;
							else if (code == OPT_SERVERID) server_len = length;
						end
						count = '0;
						if (length == 16'd0) close_option();
						else phase = PH_VALUE;
					end
				end
				PH_VALUE: begin
					pos = count;
					if (relay_seen) begin
						if (code == OPT_CLIENTID) push_data(KIND_CLIENT, pos, b);
						else if (code == OPT_SERVERID) push_data(KIND_SERVER, pos, b);
						else if (code == OPT_IAADDR && pos < ADDR_BYTES) push_data(KIND_ADDR, pos, b);
					end
					count = count + 16'd1;
					if (count >= length) close_option();
				end
				PH_INNER: begin
					inner = b;
					relay_seen = 1'b1;
					if (b != MSG_ADVERTISE) begin
						halted = 1'b1;
					end else begin
						count = '0;
						phase = PH_TXID;
					end
				end
				PH_TXID: begin
					push_data(KIND_TXID, count, b);
					count = count + 16'd1;
					if (count >= TXID_BYTES) begin
						found[0] = 1'b1;
						phase = PH_CODE_HI;
					end
				end
				PH_IANA: begin
					count = count + 16'd1;
					if (count >= IANA_SKIP) phase = PH_CODE_HI;
				end
				default: phase = PH_CODE_HI;
				endcase
			end

			if (eom) begin
				if (halted && phase == PH_TYPE) verdict = ST_OTHER;
				else if (relay_seen && inner == MSG_REPLY) verdict = ST_REPLY;
				else if (relay_seen && inner != MSG_ADVERTISE) verdict = ST_OTHER;
				else if (found == ALL_FOUND) verdict = ST_ADVERTISE;
				else verdict = ST_INCOMPLETE;
				r = '0;
				r.kind = KIND_STATUS;
				r.inner_msg_type = inner;
				r.status = verdict;
				r.client_id_len = client_len;
				r.server_id_len = server_len;
				expected_records.push_back(r);
				verdicts[verdict]++;
				messages_closed++;
				restart();
			end
			if (expected_records.size() > start_len) expected_records[$].run_last = 1'b1;
		endtask

		task check_result(res_t got);
			res_t want;
			string diffs;
			records_checked++;
			if (expected_records.size() == 0) begin
				report({"output request with nothing owed: ", describe(got)});
			end else begin
				want = expected_records.pop_front();
				diffs = "";
				if (got.kind !== want.kind) diffs = {diffs, " kind"};
				if (got.field_index !== want.field_index) diffs = {diffs, " field_index"};
				if (got.data_byte !== want.data_byte) diffs = {diffs, " data_byte"};
				if (got.inner_msg_type !== want.inner_msg_type) diffs = {diffs, " inner_msg_type"};
				if (got.status !== want.status) diffs = {diffs, " status"};
				if (got.client_id_len !== want.client_id_len) diffs = {diffs, " client_id_len"};
				if (got.server_id_len !== want.server_id_len) diffs = {diffs, " server_id_len"};
				if (got.run_last !== want.run_last) diffs = {diffs, " run_last"};
				if (diffs != "")
					report($sformatf("record %0d wrong in%s: got %s, wanted %s", records_checked,
						diffs, describe(got), describe(want)));
			end
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [7:0] in_byte = '0;
	logic end_of_message = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [2:0] kind;
	logic [15:0] field_index;
	logic [7:0] data_byte;
	logic [7:0] inner_msg_type;
	logic [1:0] status;
	logic [15:0] client_id_len;
	logic [15:0] server_id_len;
	logic run_last;

	// Idling switches, changed once per message so that there are long stretches with
	// gaps and stalls and long stretches without them.
	bit send_idle = 1'b0;
	bit recv_idle = 1'b0;
	int stall_left;

	logic [7:0] msg_bytes[$];
	option_parse_scoreboard sb;

	dhcpv6_relay_reply_option_parser dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_byte(in_byte),
		.end_of_message(end_of_message),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.kind(kind),
		.field_index(field_index),
		.data_byte(data_byte),
		.inner_msg_type(inner_msg_type),
		.status(status),
		.client_id_len(client_id_len),
		.server_id_len(server_id_len),
		.run_last(run_last)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Output side. Values are sampled at the clock edge before any of this edge's updates land,
	// so a request is taken exactly when the block sees valid high and stall low.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left <= 0;
		end else begin
			if (out_valid === 1'b1 && !out_stall)
				sb.check_result(res_t'({kind, field_index, data_byte, inner_msg_type, status,
					client_id_len, server_id_len, run_last}));
			if (stall_left != 0) begin
				stall_left <= stall_left - 1;
				out_stall <= 1'b1;
			end else if (recv_idle && $urandom_range(0, 5) == 0) begin
				stall_left <= $urandom_range(0, 4);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Offers one byte and waits until the block takes it. A gap, when there is one, lowers
	// valid before it rises again, and the payload holds while stalled.
	task automatic send_byte(input logic [7:0] b, input logic eom);
		if (send_idle && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte <= b;
		end_of_message <= eom;
		do @(posedge clk); while (in_stall);
		sb.parse_byte(b, eom);
	endtask

	// Holds the input back until every owed output request has come out.
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.expected_records.size() != 0) @(posedge clk);
	endtask

	function automatic void push16(logic [15:0] v);
		msg_bytes.push_back(v[15:8]);
		msg_bytes.push_back(v[7:0]);
	endfunction

	function automatic void push_random(int n);
		for (int i = 0; i < n; i++) msg_bytes.push_back(8'($urandom));
	endfunction

	// An option the parser does not know, with a short random value. Codes below ten are
	// avoided so that it cannot be mistaken for a pad or for one of the tracked options.
	function automatic void push_unknown_option();
		int len;
		push16(($urandom_range(0, 3) == 0) ? 16'hffff : 16'($urandom_range(10, 16'hfffe)));
		len = $urandom_range(0, 4);
		push16(16'(len));
		push_random(len);
	endfunction

	function automatic void push_duid_option(logic [15:0] opt);
		int len;
		len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(0, 12);
		push16(opt);
		push16(16'(len));
		push_random(len);
	endfunction

	// Builds one message in msg_bytes. Well-formed messages carry the relay header, up to two
	// options ahead of the relay message, the relay message itself and then the client ID,
	// server ID and IA_NA (with its IAADDR) in a random order, with pads and unknown options
	// mixed in. The other scenarios bend or break that shape.
	function automatic void build_message(scenario_t sc);
		int part[4];
		int j, t, cut, len;
		logic [7:0] itype;
		msg_bytes.delete();

		if (sc == SC_NOISE) begin
			msg_bytes.push_back($urandom_range(0, 1) ? MSG_RELAY_REPLY : 8'($urandom));
			push_random($urandom_range(0, 60));
			return;
		end

		if (sc == SC_WRONG_TYPE) begin
			do itype = 8'($urandom); while (itype == MSG_RELAY_REPLY);
			msg_bytes.push_back(itype);
		end else begin
			msg_bytes.push_back(MSG_RELAY_REPLY);
		end
		push_random(RELAY_HEADER_BYTES - 1);

		// A truncated message may sit inside an option that claims the largest length.
		if (sc == SC_TRUNCATED && $urandom_range(0, 2) == 0) begin
			push16(16'($urandom_range(10, 16'hffff)));
			push16(16'hffff);
			push_random(20);
			cut = $urandom_range(1, msg_bytes.size());
			while (msg_bytes.size() > cut) void'(msg_bytes.pop_back());
			return;
		end

		// Options ahead of the relay message are skipped, even ones whose codes are tracked.
		repeat ($urandom_range(0, 2)) begin
			case ($urandom_range(0, 2))
			0: push16(OPT_PAD);
			1: push_unknown_option();
			default: push_duid_option($urandom_range(0, 1) ? OPT_CLIENTID : OPT_IA_NA);
			endcase
		end

		push16(OPT_RELAY_MSG);
		push16($urandom_range(0, 3) == 0 ? 16'hffff : 16'($urandom));
		if (sc == SC_REPLY) begin
			itype = MSG_REPLY;
		end else if (sc == SC_OTHER_TYPE) begin
			do itype = ($urandom_range(0, 2) == 0) ? 8'hff : 8'($urandom);
			while (itype == MSG_ADVERTISE || itype == MSG_REPLY);
		end else begin
			itype = MSG_ADVERTISE;
		end
		msg_bytes.push_back(itype);
		push_random(TXID_BYTES);

		for (int i = 0; i < 4; i++) part[i] = i;
		for (int i = 3; i > 0; i--) begin
			j = $urandom_range(0, i);
			t = part[i];
			part[i] = part[j];
			part[j] = t;
		end

		for (int i = 0; i < 4; i++) begin
			case ($urandom_range(0, 5))
			0: push16(OPT_PAD);
			1: push_unknown_option();
			default: ;
			endcase
			// Now and then a tracked option is left out, which leaves the message incomplete.
			if ($urandom_range(0, 11) != 0) begin
				case (part[i])
				0: push_duid_option(OPT_CLIENTID);
				1: push_duid_option(OPT_SERVERID);
				2: begin
					push16(OPT_IA_NA);
					push_random(IANA_SKIP);
					push16(OPT_IAADDR);
					len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 30) : 24;
					push16(16'(len));
					push_random(len);
				end
				default: begin
					if (sc == SC_SECOND_RELAY) begin
						push16(OPT_RELAY_MSG);
						len = $urandom_range(0, 6);
						push16(16'(len));
						push_random(len);
					end else if ($urandom_range(0, 1) == 0) begin
						push_unknown_option();
					end
				end
				endcase
			end
		end

		// Trailing bytes follow the last option; once the parse has stopped they must be ignored.
		push_random($urandom_range(0, 3));

		if (sc == SC_TRUNCATED) begin
			cut = $urandom_range(1, msg_bytes.size());
			while (msg_bytes.size() > cut) void'(msg_bytes.pop_back());
		end
	endfunction

	// Safety net: generous compared with the slowest correct run.
	initial begin
		#4800000;
		$display("Timed out with %0d output requests still owed.", sb.expected_records.size());
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		int msgs;
		int pick;
		scenario_t sc;
		sb = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Short directed messages: wrong first byte at both extremes, a relay-reply type byte that
		// ends the message at once, one cut short in its header, and bytes arriving after a wrong type.
		send_byte(8'h00, 1'b1);
		send_byte(8'hff, 1'b1);
		send_byte(MSG_RELAY_REPLY, 1'b1);
		send_byte(MSG_RELAY_REPLY, 1'b0);
		send_byte(8'hff, 1'b0);
		send_byte(8'h00, 1'b1);
		send_byte(8'h0c, 1'b0);
		send_byte(8'h5a, 1'b0);
		send_byte(8'ha5, 1'b1);
		drain();

		// The first pass goes through every scenario once; after that they are drawn at
		// random, weighted towards well-formed messages. Idling stops near the end.
		for (msgs = 0; sb.bytes_taken < BYTE_TARGET; msgs++) begin
			if (msgs < SCENARIO_COUNT) begin
				sc = scenario_t'(msgs);
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 45) sc = SC_ADVERTISE;
				else if (pick < 57) sc = SC_SECOND_RELAY;
				else if (pick < 72) sc = SC_TRUNCATED;
				else if (pick < 78) sc = SC_REPLY;
				else if (pick < 84) sc = SC_OTHER_TYPE;
				else if (pick < 90) sc = SC_WRONG_TYPE;
				else sc = SC_NOISE;
			end
			if (sb.bytes_taken < BYTE_TARGET * 85 / 100) begin
				send_idle = ($urandom_range(0, 2) != 0);
				recv_idle = ($urandom_range(0, 2) != 0);
			end else begin
				send_idle = 1'b0;
				recv_idle = 1'b0;
			end
			build_message(sc);
			foreach (msg_bytes[i]) send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
			if (msgs == 2 || $urandom_range(0, 7) == 0) drain();
		end

		drain();
		repeat (16) @(posedge clk);

		$display("Ran %0d messages in %0d input requests: %0d advertise, %0d reply, %0d other, %0d incomplete.",
			sb.messages_closed, sb.bytes_taken, sb.verdicts[ST_ADVERTISE], sb.verdicts[ST_REPLY],
			sb.verdicts[ST_OTHER], sb.verdicts[ST_INCOMPLETE]);
		$display("Checked %0d output requests, %0d mismatches.", sb.records_checked, sb.mismatches);
		if (sb.mismatches == 0 && sb.expected_records.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
